>>> sv/fat12_pkg.sv
// Shared definitions for the FAT12 cluster table core: request codes,
// configuration register indexes, field widths and geometry reset values.
// No dependencies.
package fat12_pkg;

  localparam int unsigned TABLE_BYTES_DEF = 8192;

  // request codes carried on in_tuser
  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_LOAD  = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_BYTES_PER_SECTOR    = 3'd0;
  localparam logic [2:0] CFG_SECTORS_PER_CLUSTER = 3'd1;
  localparam logic [2:0] CFG_RESERVED_SECTORS    = 3'd2;
  localparam logic [2:0] CFG_TABLE_COPIES        = 3'd3;
  localparam logic [2:0] CFG_SECTORS_PER_TABLE   = 3'd4;
  localparam logic [2:0] CFG_ROOT_ENTRIES        = 3'd5;
  localparam logic [2:0] CFG_TOTAL_SECTORS       = 3'd6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam int IN_DATA_W  = 48;  // 45 payload bits, padded to bytes
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 80;  // 78 payload bits, padded to bytes

  localparam logic [12:0] RST_BYTES_PER_SECTOR    = 13'd512;
  localparam logic [7:0]  RST_SECTORS_PER_CLUSTER = 8'd1;
  localparam logic [15:0] RST_RESERVED_SECTORS    = 16'd1;
  localparam logic [2:0]  RST_TABLE_COPIES        = 3'd2;
  localparam logic [15:0] RST_SECTORS_PER_TABLE   = 16'd9;
  localparam logic [15:0] RST_ROOT_ENTRIES        = 16'd224;
  localparam logic [15:0] RST_TOTAL_SECTORS       = 16'd2880;

  localparam logic [11:0] EOC_MIN       = 12'hFF8;
  localparam logic [11:0] CLUSTER_FIRST = 12'd2;
  localparam logic [11:0] CLUSTER_LAST  = 12'hFF6;

endpackage

>>> sv/fat12_cluster_table_core.sv
// FAT12 cluster table core: table byte store, entry read and
// read-modify-write sequencer, and volume geometry unit.
// Depends on fat12_pkg.
//
// The allocation table lives in a single-port byte RAM of TABLE_BYTES bytes
// with a registered read. Byte 0 is the first table byte; load requests fill
// it one byte at a time, and a table byte must be loaded before any entry
// that covers it is read or written. A load writes its byte on accept, a
// read makes two RAM reads for the two bytes of the packed entry and a
// write makes one RAM read of the shared byte, then two RAM writes; the
// single RAM port serializes these accesses. Every result also carries the
// end-of-chain flag, cluster validity and the root directory and cluster
// data byte offsets, from a free-running multiply pipeline; validity uses
// a bit-serial divider (total sectors over sectors per cluster) rerun after
// reset and after every configuration write, and in_tready stays low while
// the divider is starting or busy.
module fat12_cluster_table_core
  import fat12_pkg::*;
#(
  parameter int unsigned TABLE_BYTES = TABLE_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [11:0] cluster_num, [23:12] entry_in, [36:24] load_index,
  // [44:37] load_byte, [47:45] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [1:0] req_type
  input  logic [IN_USER_W-1:0]  in_tuser,
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [11:0] entry_value, [12] end_of_chain, [13] cluster_valid,
  // [45:14] root_dir_offset, [77:46] cluster_offset, [79:78] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(TABLE_BYTES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD2,
    ST_WR1,
    ST_WR2,
    ST_DONE
  } state_t;

  // ---------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------
  logic [12:0] bps_r;
  logic [7:0]  spc_r;
  logic [15:0] rsv_r;
  logic [2:0]  copies_r;
  logic [15:0] spt_r;
  logic [15:0] root_ent_r;
  logic [15:0] tot_sec_r;

  logic cfg_wr;
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bps_r      <= RST_BYTES_PER_SECTOR;
      spc_r      <= RST_SECTORS_PER_CLUSTER;
      rsv_r      <= RST_RESERVED_SECTORS;
      copies_r   <= RST_TABLE_COPIES;
      spt_r      <= RST_SECTORS_PER_TABLE;
      root_ent_r <= RST_ROOT_ENTRIES;
      tot_sec_r  <= RST_TOTAL_SECTORS;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_BYTES_PER_SECTOR:    bps_r      <= cfg_data[12:0];
        CFG_SECTORS_PER_CLUSTER: spc_r      <= cfg_data[7:0];
        CFG_RESERVED_SECTORS:    rsv_r      <= cfg_data;
        CFG_TABLE_COPIES:        copies_r   <= cfg_data[2:0];
        CFG_SECTORS_PER_TABLE:   spt_r      <= cfg_data;
        CFG_ROOT_ENTRIES:        root_ent_r <= cfg_data;
        CFG_TOTAL_SECTORS:       tot_sec_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // geometry: free-running multiply pipeline plus bit-serial divider
  // ---------------------------------------------------------------------
  logic [19:0] sec_r;         // reserved + copies * sectors per table
  logic [31:0] root_off_r;
  logic [31:0] base_r;        // first data cluster offset
  logic [20:0] clus_bytes_r;  // bytes in one cluster

  logic [32:0] root_prod;
  assign root_prod = bps_r * sec_r;

  always_ff @(posedge clk) begin
    sec_r        <= 20'(rsv_r) + 20'(copies_r) * 20'(spt_r);
    root_off_r   <= root_prod[31:0];
    base_r       <= root_off_r + 32'({root_ent_r, 5'b0});
    clus_bytes_r <= bps_r * spc_r;
  end

  logic        geo_start_r;
  logic        geo_busy_r;
  logic [4:0]  geo_cnt_r;
  logic [7:0]  rem_r;
  logic [15:0] quo_r;

  logic [8:0]  div_shift;
  logic        div_ge;
  logic [8:0]  div_diff;
  assign div_shift = {rem_r, quo_r[15]};
  assign div_ge    = div_shift >= {1'b0, spc_r};
  assign div_diff  = div_shift - {1'b0, spc_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geo_start_r <= 1'b1;
      geo_busy_r  <= 1'b0;
      geo_cnt_r   <= '0;
    end else begin
      if (cfg_wr) begin
        geo_start_r <= 1'b1;
      end else if (geo_start_r) begin
        geo_start_r <= 1'b0;
      end
      if (geo_start_r) begin
        geo_busy_r <= 1'b1;
        geo_cnt_r  <= 5'd16;
      end else if (geo_busy_r) begin
        geo_cnt_r <= geo_cnt_r - 5'd1;
        if (geo_cnt_r == 5'd1) begin
          geo_busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (geo_start_r) begin
      rem_r <= '0;
      quo_r <= tot_sec_r;
    end else if (geo_busy_r) begin
      rem_r <= div_ge ? div_diff[7:0] : div_shift[7:0];
      quo_r <= {quo_r[14:0], div_ge};
    end
  end

  logic [11:0] max_clusters;
  assign max_clusters = (spc_r == 8'd0) ? 12'd0 : quo_r[11:0];

  // ---------------------------------------------------------------------
  // request sequencer
  // ---------------------------------------------------------------------
  logic [1:0]  in_req;
  logic [11:0] in_cl;
  logic [11:0] in_ev;
  logic [12:0] in_li;
  logic [7:0]  in_lb;
  assign in_req = in_tuser[1:0];
  assign in_cl  = in_tdata[11:0];
  assign in_ev  = in_tdata[23:12];
  assign in_li  = in_tdata[36:24];
  assign in_lb  = in_tdata[44:37];

  state_t      state_r;
  logic [1:0]  req_r;
  logic [11:0] cl_r;
  logic [11:0] ev_r;
  logic [12:0] p1_r;     // first byte of the entry
  logic [31:0] prod_r;   // cluster bytes * (cluster - 2)
  logic [7:0]  lo_r;     // first byte read
  logic [7:0]  rd_r;     // RAM read data
  logic        out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic accept;
  logic out_free;
  assign in_tready = (state_r == ST_IDLE) && !geo_start_r && !geo_busy_r;
  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  logic [12:0] in_p1;
  logic [12:0] p2;
  logic [34:0] in_prod;
  assign in_p1   = 13'({in_cl[11:1], 1'b0}) + 13'(in_cl[11:1]) + 13'(in_cl[0]);
  assign p2      = p1_r + 13'd1;
  assign in_prod = $signed({1'b0, clus_bytes_r}) * $signed({1'b0, in_cl} - 13'd2);

  // RAM port control
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = AW'(p1_r);
    mem_wdata = ev_r[7:0];
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          priority if (in_req == REQ_READ) begin
            mem_re   = 1'b1;
            mem_addr = AW'(in_p1);
          end else if (in_req == REQ_WRITE) begin
            // fetch the byte shared with the neighbor entry
            mem_re   = 1'b1;
            mem_addr = in_cl[0] ? AW'(in_p1) : AW'(in_p1 + 13'd1);
          end else if (in_req == REQ_LOAD) begin
            mem_we    = 32'(in_li) < TABLE_BYTES;
            mem_addr  = AW'(in_li);
            mem_wdata = in_lb;
          end else begin
          end
        end
      end
      ST_RD2: begin
        mem_re   = 1'b1;
        mem_addr = AW'(p2);
      end
      ST_WR1: begin
        mem_we = 1'b1;
        if (cl_r[0]) begin
          mem_addr  = AW'(p2);
          mem_wdata = ev_r[11:4];
        end else begin
          mem_addr  = AW'(p1_r);
          mem_wdata = ev_r[7:0];
        end
      end
      ST_WR2: begin
        mem_we = 1'b1;
        if (cl_r[0]) begin
          mem_addr  = AW'(p1_r);
          mem_wdata = {ev_r[3:0], rd_r[3:0]};
        end else begin
          mem_addr  = AW'(p2);
          mem_wdata = {rd_r[7:4], ev_r[11:8]};
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  logic [7:0] table_mem [TABLE_BYTES];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_r <= table_mem[mem_addr];
    end
  end

  // result assembly
  logic [11:0] res_val;
  logic        res_eoc;
  logic        res_valid_cl;
  logic [31:0] res_clus_off;

  always_comb begin
    unique case (req_r)
      REQ_READ:  res_val = cl_r[0] ? {rd_r, lo_r[7:4]} : {rd_r[3:0], lo_r};
      REQ_WRITE: res_val = ev_r;
      default:   res_val = '0;
    endcase
    res_eoc      = ((req_r == REQ_READ) || (req_r == REQ_WRITE)) && (res_val >= EOC_MIN);
    res_valid_cl = (cl_r >= CLUSTER_FIRST) && (cl_r <= CLUSTER_LAST) &&
                   (cl_r < max_clusters);
    res_clus_off = (cl_r == 12'd0) ? root_off_r : base_r + prod_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            priority if (in_req == REQ_READ) begin
              state_r <= ST_RD2;
            end else if (in_req == REQ_WRITE) begin
              state_r <= ST_WR1;
            end else begin
              state_r <= ST_DONE;
            end
          end
        end
        ST_RD2:  state_r <= ST_DONE;
        ST_WR1:  state_r <= ST_WR2;
        ST_WR2:  state_r <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      // hold the result until taken
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
        out_data_r  <= {2'b00, res_clus_off, root_off_r, res_valid_cl, res_eoc, res_val};
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= in_req;
      cl_r   <= in_cl;
      ev_r   <= in_ev;
      p1_r   <= in_p1;
      prod_r <= in_prod[31:0];
    end
    if (state_r == ST_RD2) begin
      lo_r <= rd_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("table RAM read and written in the same cycle");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_DONE))
    else $error("result raised without a finished item");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    geo_busy_r |-> geo_cnt_r != 5'd0)
    else $error("divider busy with an empty count");

  a_eoc_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[12] |-> out_tdata[11:3] == 9'h1FF)
    else $error("end of chain flagged outside the reserved range");

endmodule
